// ===== hdl/flc_pkg.sv =====
// ----------------------------------------------------------------------------
// flc_pkg: shared types, constants and helpers for facet lighting cosines
// Widths of the datapath, the light position table and the rounding helpers.
// ----------------------------------------------------------------------------
package flc_pkg;

  // Default number of light positions in the table.
  localparam int NUM_LEDS_DEF = 16;

  // Configuration register indexes and address width.
  localparam logic [1:0] REG_CAMERA_X = 2'd0;
  localparam logic [1:0] REG_CAMERA_Y = 2'd1;
  localparam logic [1:0] REG_CAMERA_Z = 2'd2;
  localparam int ADDR_W = 4;

  // Coordinate and vector widths.
  localparam int CW  = 24;   // Q12.12 coordinate
  localparam int EW  = 25;   // edge vector component
  localparam int SW  = 26;   // vertex sum, three times the centroid
  localparam int LW  = 29;   // light, view and half vector components
  localparam int PW  = 50;   // cross product partial product
  localparam int VW  = 50;   // vector component entering normalization
  localparam int MW  = VW - 1;  // magnitude of one component
  localparam int NW  = 30;   // magnitude after normalizing shift
  localparam int SQW = 2 * NW + 2;  // sum of three squares
  localparam int RW  = SQW + 1;     // square root working registers
  localparam int SQ_STEPS = SQW / 2;  // square root iterations, one per stage
  localparam int SQ_TOP = 2 * (SQ_STEPS - 1);
  localparam int QW  = 15;   // quotient bits of one unit component
  localparam int DW  = NW + QW + 1;  // division remainder width
  localparam int UW  = 16;   // Q1.14 output width
  localparam int XW  = 40;   // width of dot product sums before rounding

  // Cycles through the normalization unit.
  localparam int ULAT = 5 + SQ_STEPS + 1 + QW + 1;

  localparam logic signed [XW-1:0] ONE14 = XW'(16384);
  localparam logic signed [XW-1:0] HALF14 = XW'(8192);

  // Light positions, already multiplied by three (Q12.12).
  localparam logic signed [CW-1:0] LED_Y3 [4] = '{
    24'sd3072000, 24'sd1781760, 24'sd430080, -24'sd860160
  };
  localparam logic signed [CW-1:0] LED_X3 [4] = '{
    24'sd1055889, 24'sd2173959, 24'sd3052899, 24'sd3596025
  };
  localparam logic signed [CW-1:0] LED_Z3 [4] = '{
    24'sd3596025, 24'sd3052899, 24'sd2173959, 24'sd1055889
  };

  // Result of one normalization unit.
  typedef struct packed {
    logic               ok;
    logic signed [UW-1:0] x;
    logic signed [UW-1:0] y;
    logic signed [UW-1:0] z;
  } unit_t;

  // Round a Q2.28 product sum to Q1.14, halves rounding up.
  function automatic logic signed [XW-1:0] rnd14(input logic signed [XW-1:0] d);
    rnd14 = (d + HALF14) >>> 14;
  endfunction

  // Clamp a cosine to the closed range of minus one to one.
  function automatic logic signed [UW-1:0] clamp14(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] t;
    t = v;
    if (t > ONE14) t = ONE14;
    else if (t < -ONE14) t = -ONE14;
    clamp14 = UW'(t);
  endfunction

endpackage

// ===== hdl/flc_unit3.sv =====
// ----------------------------------------------------------------------------
// flc_unit3: pipelined normalization of one 3-vector to a Q1.14 unit vector
// Magnitude, normalizing shift, sum of squares, bit-per-stage square root and
// three bit-per-stage restoring dividers. One vector enters in every enabled
// cycle; every stage holds while en is low.
// ----------------------------------------------------------------------------
module flc_unit3 (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [flc_pkg::VW-1:0] vin [3],
  output flc_pkg::unit_t               uout
);

  localparam int VW = flc_pkg::VW;
  localparam int MW = flc_pkg::MW;
  localparam int NW = flc_pkg::NW;
  localparam int SQW = flc_pkg::SQW;
  localparam int RW = flc_pkg::RW;
  localparam int SQ_STEPS = flc_pkg::SQ_STEPS;
  localparam int QW = flc_pkg::QW;
  localparam int DW = flc_pkg::DW;
  localparam int UW = flc_pkg::UW;

  // Magnitudes, signs and the OR of all magnitudes for the shift search.
  logic [MW-1:0] mag_in [3];
  logic [MW-1:0] or_in;
  logic [MW-1:0] m1 [3];
  logic [MW-1:0] o1;
  logic [2:0]    neg1;
  logic          z1;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag_in[k] = vin[k][VW-1] ? MW'(-vin[k]) : MW'(vin[k]);
    end
    or_in = mag_in[0] | mag_in[1] | mag_in[2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1 <= mag_in;
      o1 <= or_in;
      for (int k = 0; k < 3; k++) begin
        neg1[k] <= vin[k][VW-1];
      end
      z1 <= (or_in == '0);
    end
  end

  // Left-justify the largest magnitude: coarse steps of 32, 16 and 8.
  logic [MW-1:0] ma [3];
  logic [MW-1:0] oa;
  logic [MW-1:0] m2 [3];
  logic [MW-1:0] o2;
  logic [2:0]    neg2;
  logic          z2;

  always_comb begin
    ma = m1;
    oa = o1;
    if (oa[MW-1 -: 32] == '0) begin
      oa = oa << 32;
      for (int k = 0; k < 3; k++) ma[k] = ma[k] << 32;
    end
    if (oa[MW-1 -: 16] == '0) begin
      oa = oa << 16;
      for (int k = 0; k < 3; k++) ma[k] = ma[k] << 16;
    end
    if (oa[MW-1 -: 8] == '0) begin
      oa = oa << 8;
      for (int k = 0; k < 3; k++) ma[k] = ma[k] << 8;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2   <= ma;
      o2   <= oa;
      neg2 <= neg1;
      z2   <= z1;
    end
  end

  // Fine steps of 4, 2 and 1, then drop to NW bits with the top bit at NW-1.
  logic [MW-1:0] mb [3];
  logic [MW-1:0] ob;
  logic [NW-1:0] m3 [3];
  logic [2:0]    neg3;
  logic          z3;

  always_comb begin
    mb = m2;
    ob = o2;
    if (ob[MW-1 -: 4] == '0) begin
      ob = ob << 4;
      for (int k = 0; k < 3; k++) mb[k] = mb[k] << 4;
    end
    if (ob[MW-1 -: 2] == '0) begin
      ob = ob << 2;
      for (int k = 0; k < 3; k++) mb[k] = mb[k] << 2;
    end
    if (!ob[MW-1]) begin
      ob = ob << 1;
      for (int k = 0; k < 3; k++) mb[k] = mb[k] << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        m3[k] <= NW'(mb[k] >> (MW - NW));
      end
      neg3 <= neg2;
      z3   <= z2;
    end
  end

  // Squares of the normalized magnitudes.
  logic [2*NW-1:0] sq4 [3];
  logic [NW-1:0]   m4 [3];
  logic [2:0]      neg4;
  logic            z4;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        sq4[k] <= m3[k] * m3[k];
      end
      m4   <= m3;
      neg4 <= neg3;
      z4   <= z3;
    end
  end

  // Square root pipeline: stage 0 holds the sum of squares.
  logic [RW-1:0] sx [SQ_STEPS+1];
  logic [RW-1:0] sr [SQ_STEPS+1];
  logic [NW-1:0] smag [SQ_STEPS+1][3];
  logic [2:0]    sneg [SQ_STEPS+1];
  logic          sz [SQ_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      sx[0]   <= RW'(SQW'(sq4[0]) + SQW'(sq4[1]) + SQW'(sq4[2]));
      sr[0]   <= '0;
      smag[0] <= m4;
      sneg[0] <= neg4;
      sz[0]   <= z4;
    end
  end

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
    localparam logic [RW-1:0] BIT = RW'(1) << (flc_pkg::SQ_TOP - 2 * j);
    logic [RW-1:0] trial;
    logic          take;

    assign trial = sr[j] + BIT;
    assign take  = (sx[j] >= trial);

    // One result bit per stage.
    always_ff @(posedge clk) begin
      if (en) begin
        sx[j+1]   <= take ? sx[j] - trial : sx[j];
        sr[j+1]   <= take ? (sr[j] >> 1) + BIT : sr[j] >> 1;
        smag[j+1] <= smag[j];
        sneg[j+1] <= sneg[j];
        sz[j+1]   <= sz[j];
      end
    end
  end

  // Division pipeline: stage 0 holds the rounded numerators and the length.
  logic [NW:0]   len_w;
  logic [DW-1:0] drem [QW+1][3];
  logic [QW-1:0] dq [QW+1][3];
  logic [NW:0]   dlen [QW+1];
  logic [2:0]    dneg [QW+1];
  logic          dz [QW+1];

  assign len_w = sr[SQ_STEPS][NW:0];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        drem[0][k] <= (DW'(smag[SQ_STEPS][k]) << 14) + DW'(len_w >> 1);
        dq[0][k]   <= '0;
      end
      dlen[0] <= len_w;
      dneg[0] <= sneg[SQ_STEPS];
      dz[0]   <= sz[SQ_STEPS];
    end
  end

  for (genvar t = 0; t < QW; t++) begin : g_div
    localparam int B = QW - 1 - t;
    logic [DW-1:0] dtrial;

    assign dtrial = DW'(dlen[t]) << B;

    // One quotient bit per stage for each component.
    always_ff @(posedge clk) begin
      if (en) begin
        for (int k = 0; k < 3; k++) begin
          if (drem[t][k] >= dtrial) begin
            drem[t+1][k] <= drem[t][k] - dtrial;
            dq[t+1][k]   <= dq[t][k] | (QW'(1) << B);
          end else begin
            drem[t+1][k] <= drem[t][k];
            dq[t+1][k]   <= dq[t][k];
          end
        end
        dlen[t+1] <= dlen[t];
        dneg[t+1] <= dneg[t];
        dz[t+1]   <= dz[t];
      end
    end
  end

  // Restore the signs; a zero vector gives a zero result.
  logic signed [UW-1:0] qs [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (dz[QW]) qs[k] = '0;
      else if (dneg[QW][k]) qs[k] = -$signed(UW'(dq[QW][k]));
      else qs[k] = $signed(UW'(dq[QW][k]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      uout.ok <= !dz[QW];
      uout.x  <= qs[0];
      uout.y  <= qs[1];
      uout.z  <= qs[2];
    end
  end

endmodule

// ===== hdl/facet_lighting_cosines_core.sv =====
// ----------------------------------------------------------------------------
// facet_lighting_cosines_core: per-triangle lighting angle cosines
// Unit face normal of a triangle and the cosines between light, normal, half
// vector, reflection and view, with a camera position set over APB.
//
//   Channel  Handshake             Payload
//   in       in_valid / in_ready   vertex_{a,b,c}_{x,y,z}, led_index
//   out      out_valid / out_ready normal_{x,y,z}, cos_*, degenerate
//   apb      psel / penable        paddr, pwdata, prdata (camera_x/y/z)
//
// One triangle is taken in every cycle in which the pipeline advances. Most
// of the pipeline's stages lie in the bit-per-stage square root and
// dividers inside the normalization units.
// Reset clears all valid bits and the camera registers to zero.
// The whole pipeline advances when the output register is empty or taken;
// while a result waits, every stage holds, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module facet_lighting_cosines_core #(
  parameter int NUM_LEDS = flc_pkg::NUM_LEDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // APB configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [flc_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // Input items
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [23:0]            vertex_a_x,
  input  logic signed [23:0]            vertex_a_y,
  input  logic signed [23:0]            vertex_a_z,
  input  logic signed [23:0]            vertex_b_x,
  input  logic signed [23:0]            vertex_b_y,
  input  logic signed [23:0]            vertex_b_z,
  input  logic signed [23:0]            vertex_c_x,
  input  logic signed [23:0]            vertex_c_y,
  input  logic signed [23:0]            vertex_c_z,
  input  logic [3:0]                    led_index,
  // Result items
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [15:0]            normal_x,
  output logic signed [15:0]            normal_y,
  output logic signed [15:0]            normal_z,
  output logic signed [15:0]            cos_light_normal,
  output logic signed [15:0]            cos_normal_half,
  output logic signed [15:0]            cos_reflect_view,
  output logic                          degenerate
);

  localparam int CW = flc_pkg::CW;
  localparam int EW = flc_pkg::EW;
  localparam int SW = flc_pkg::SW;
  localparam int LW = flc_pkg::LW;
  localparam int PW = flc_pkg::PW;
  localparam int VW = flc_pkg::VW;
  localparam int UW = flc_pkg::UW;
  localparam int XW = flc_pkg::XW;
  localparam int UOUT = 3 + flc_pkg::ULAT;   // stage index of unit results
  localparam int NST = UOUT + 7;             // total pipeline stages
  localparam int RVW = 20;                   // reflection component width

  // Camera registers and APB access.
  logic signed [CW-1:0] camera_x;
  logic signed [CW-1:0] camera_y;
  logic signed [CW-1:0] camera_z;
  logic [1:0]           reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      camera_x <= '0;
      camera_y <= '0;
      camera_z <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        flc_pkg::REG_CAMERA_X: camera_x <= pwdata[CW-1:0];
        flc_pkg::REG_CAMERA_Y: camera_y <= pwdata[CW-1:0];
        flc_pkg::REG_CAMERA_Z: camera_z <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      flc_pkg::REG_CAMERA_X: prdata = {8'b0, camera_x};
      flc_pkg::REG_CAMERA_Y: prdata = {8'b0, camera_y};
      flc_pkg::REG_CAMERA_Z: prdata = {8'b0, camera_z};
      default:               prdata = '0;
    endcase
  end

  // Pipeline advance and valid bits.
  logic           en;
  logic [NST-1:0] vld;

  assign en       = !vld[NST-1] || out_ready;
  assign in_ready = en;
  assign out_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], in_valid};
    end
  end

  // Light index wrapped to the table size.
  logic [3:0] led_wrap [16];

  for (genvar i = 0; i < 16; i++) begin : g_wrap
    localparam logic [3:0] SEL = 4'(i % NUM_LEDS);
    assign led_wrap[i] = SEL;
  end

  // Stage 1: register the item.
  logic signed [CW-1:0] va [3];
  logic signed [CW-1:0] vb [3];
  logic signed [CW-1:0] vc [3];
  logic [3:0]           idx1;

  always_ff @(posedge clk) begin
    if (en) begin
      va[0] <= vertex_a_x;  va[1] <= vertex_a_y;  va[2] <= vertex_a_z;
      vb[0] <= vertex_b_x;  vb[1] <= vertex_b_y;  vb[2] <= vertex_b_z;
      vc[0] <= vertex_c_x;  vc[1] <= vertex_c_y;  vc[2] <= vertex_c_z;
      idx1  <= led_wrap[led_index];
    end
  end

  // Stage 2: edges, vertex sum and the tripled light, view and half vectors.
  logic signed [CW-1:0] led3 [3];
  logic signed [SW-1:0] cam3 [3];
  logic signed [CW-1:0] cam_r [3];
  logic signed [SW-1:0] vsum [3];
  logic signed [EW-1:0] e1 [3];
  logic signed [EW-1:0] e2 [3];
  logic signed [LW-1:0] lv2 [3];
  logic signed [LW-1:0] vv2 [3];
  logic signed [LW-1:0] hv2 [3];

  always_comb begin
    led3[0] = flc_pkg::LED_X3[idx1[1:0]];
    led3[1] = flc_pkg::LED_Y3[idx1[3:2]];
    led3[2] = flc_pkg::LED_Z3[idx1[1:0]];
    cam_r[0] = camera_x;
    cam_r[1] = camera_y;
    cam_r[2] = camera_z;
    for (int k = 0; k < 3; k++) begin
      cam3[k] = SW'(cam_r[k]) + (SW'(cam_r[k]) <<< 1);
      vsum[k] = SW'(va[k]) + SW'(vb[k]) + SW'(vc[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        e1[k]  <= EW'(vb[k]) - EW'(va[k]);
        e2[k]  <= EW'(vc[k]) - EW'(va[k]);
        lv2[k] <= LW'(led3[k]) - LW'(vsum[k]);
        vv2[k] <= LW'(cam3[k]) - LW'(vsum[k]);
        hv2[k] <= LW'(led3[k]) + LW'(cam3[k]) - (LW'(vsum[k]) <<< 1);
      end
    end
  end

  // Stage 3: cross product partial products.
  logic signed [PW-1:0] cp [6];
  logic signed [LW-1:0] lv3 [3];
  logic signed [LW-1:0] vv3 [3];
  logic signed [LW-1:0] hv3 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      cp[0] <= PW'(e1[1]) * PW'(e2[2]);
      cp[1] <= PW'(e1[2]) * PW'(e2[1]);
      cp[2] <= PW'(e1[2]) * PW'(e2[0]);
      cp[3] <= PW'(e1[0]) * PW'(e2[2]);
      cp[4] <= PW'(e1[0]) * PW'(e2[1]);
      cp[5] <= PW'(e1[1]) * PW'(e2[0]);
      lv3 <= lv2;
      vv3 <= vv2;
      hv3 <= hv2;
    end
  end

  // Stage 4: face normal and the vectors entering normalization.
  logic signed [VW-1:0] nvec [3];
  logic signed [VW-1:0] lvec [3];
  logic signed [VW-1:0] vvec [3];
  logic signed [VW-1:0] hvec [3];

  always_ff @(posedge clk) begin
    if (en) begin
      nvec[0] <= VW'(cp[0]) - VW'(cp[1]);
      nvec[1] <= VW'(cp[2]) - VW'(cp[3]);
      nvec[2] <= VW'(cp[4]) - VW'(cp[5]);
      for (int k = 0; k < 3; k++) begin
        lvec[k] <= VW'(lv3[k]);
        vvec[k] <= VW'(vv3[k]);
        hvec[k] <= VW'(hv3[k]);
      end
    end
  end

  // Four normalization units.
  flc_pkg::unit_t un;
  flc_pkg::unit_t ul;
  flc_pkg::unit_t uv;
  flc_pkg::unit_t uh;

  flc_unit3 u_norm_n (.clk(clk), .en(en), .vin(nvec), .uout(un));
  flc_unit3 u_norm_l (.clk(clk), .en(en), .vin(lvec), .uout(ul));
  flc_unit3 u_norm_v (.clk(clk), .en(en), .vin(vvec), .uout(uv));
  flc_unit3 u_norm_h (.clk(clk), .en(en), .vin(hvec), .uout(uh));

  // Stage C1: products for N.L and N.H.
  logic signed [UW-1:0] nu [3];
  logic signed [UW-1:0] lu [3];
  logic signed [UW-1:0] vu [3];
  logic signed [UW-1:0] hu [3];
  logic signed [2*UW-1:0] pnl [3];
  logic signed [2*UW-1:0] pnh [3];
  logic signed [UW-1:0] nu1 [3];
  logic signed [UW-1:0] lu1 [3];
  logic signed [UW-1:0] vu1 [3];
  logic [3:0]           ok1;   // {h, v, l, n}

  always_comb begin
    nu[0] = un.x;  nu[1] = un.y;  nu[2] = un.z;
    lu[0] = ul.x;  lu[1] = ul.y;  lu[2] = ul.z;
    vu[0] = uv.x;  vu[1] = uv.y;  vu[2] = uv.z;
    hu[0] = uh.x;  hu[1] = uh.y;  hu[2] = uh.z;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pnl[k] <= (2*UW)'(nu[k]) * (2*UW)'(lu[k]);
        pnh[k] <= (2*UW)'(nu[k]) * (2*UW)'(hu[k]);
      end
      nu1 <= nu;
      lu1 <= lu;
      vu1 <= vu;
      ok1 <= {uh.ok, uv.ok, ul.ok, un.ok};
    end
  end

  // Stage C2: round and clamp N.L and N.H.
  logic signed [UW-1:0] cln2;
  logic signed [UW-1:0] cnh2;
  logic signed [UW-1:0] nu2 [3];
  logic signed [UW-1:0] lu2 [3];
  logic signed [UW-1:0] vu2 [3];
  logic [3:0]           ok2;

  always_ff @(posedge clk) begin
    if (en) begin
      cln2 <= (ok1[0] && ok1[1])
              ? flc_pkg::clamp14(flc_pkg::rnd14(XW'(pnl[0]) + XW'(pnl[1]) + XW'(pnl[2])))
              : '0;
      cnh2 <= (ok1[0] && ok1[3])
              ? flc_pkg::clamp14(flc_pkg::rnd14(XW'(pnh[0]) + XW'(pnh[1]) + XW'(pnh[2])))
              : '0;
      nu2 <= nu1;
      lu2 <= lu1;
      vu2 <= vu1;
      ok2 <= ok1;
    end
  end

  // Stage C3: N.L times each normal component.
  logic signed [2*UW-1:0] tr3 [3];
  logic signed [UW-1:0]   cln3;
  logic signed [UW-1:0]   cnh3;
  logic signed [UW-1:0]   nu3 [3];
  logic signed [UW-1:0]   lu3 [3];
  logic signed [UW-1:0]   vu3 [3];
  logic [3:0]             ok3;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        tr3[k] <= (2*UW)'(cln2) * (2*UW)'(nu2[k]);
      end
      cln3 <= cln2;
      cnh3 <= cnh2;
      nu3  <= nu2;
      lu3  <= lu2;
      vu3  <= vu2;
      ok3  <= ok2;
    end
  end

  // Stage C4: reflection R = 2 (N.L) N - L.
  logic signed [RVW-1:0] rv4 [3];
  logic signed [UW-1:0]  cln4;
  logic signed [UW-1:0]  cnh4;
  logic signed [UW-1:0]  nu4 [3];
  logic signed [UW-1:0]  vu4 [3];
  logic [3:0]            ok4;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        rv4[k] <= RVW'(flc_pkg::rnd14(XW'(tr3[k]) <<< 1)) - RVW'(lu3[k]);
      end
      cln4 <= cln3;
      cnh4 <= cnh3;
      nu4  <= nu3;
      vu4  <= vu3;
      ok4  <= ok3;
    end
  end

  // Stage C5: products for R.V.
  localparam int RPW = RVW + UW;
  logic signed [RPW-1:0] prv5 [3];
  logic signed [UW-1:0]  cln5;
  logic signed [UW-1:0]  cnh5;
  logic signed [UW-1:0]  nu5 [3];
  logic [3:0]            ok5;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        prv5[k] <= RPW'(rv4[k]) * RPW'(vu4[k]);
      end
      cln5 <= cln4;
      cnh5 <= cnh4;
      nu5  <= nu4;
      ok5  <= ok4;
    end
  end

  // Output register: round and clamp R.V.
  always_ff @(posedge clk) begin
    if (en) begin
      normal_x         <= nu5[0];
      normal_y         <= nu5[1];
      normal_z         <= nu5[2];
      cos_light_normal <= cln5;
      cos_normal_half  <= cnh5;
      cos_reflect_view <= (ok5[0] && ok5[1] && ok5[2])
                          ? flc_pkg::clamp14(flc_pkg::rnd14(
                              XW'(prv5[0]) + XW'(prv5[1]) + XW'(prv5[2])))
                          : '0;
      degenerate       <= !(ok5[0] && ok5[1] && ok5[2] && ok5[3]);
    end
  end

  // A zero normal can only come from a degenerate triangle.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && normal_x == 16'sd0 && normal_y == 16'sd0 && normal_z == 16'sd0
    |-> degenerate)
    else $error("zero normal without degenerate flag");

  // The N.L and R.V cosines never leave the clamped range.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> cos_light_normal <= 16'sd16384 && cos_light_normal >= -16'sd16384
               && cos_reflect_view <= 16'sd16384 && cos_reflect_view >= -16'sd16384)
    else $error("cosine out of range");

  // Reset empties the pipeline.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for facet_lighting_cosines_core
// Drives triangles through the valid/ready input channel, sets the camera
// over APB between phases, and compares each result item with a predictor
// that recomputes the unit normal and the lighting cosines.
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 63;

  // One triangle with its light index.
  typedef struct {
    logic signed [23:0] v [9];
    logic [3:0]         led;
  } tri_t;

  // One result item.
  typedef struct packed {
    logic signed [15:0] nx, ny, nz, cln, cnh, crv;
    logic               degen;
  } shade_t;

  // Directed row: the triangle, and an expected result where it is obvious.
  typedef struct {
    tri_t   t;
    bit     typed;
    shade_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [flc_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [23:0] vax = '0, vay = '0, vaz = '0, vbx = '0, vby = '0, vbz = '0;
  logic signed [23:0] vcx = '0, vcy = '0, vcz = '0;
  logic [3:0] led_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] normal_x, normal_y, normal_z;
  logic signed [15:0] cos_light_normal, cos_normal_half, cos_reflect_view;
  logic degenerate;

  facet_lighting_cosines_core u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .vertex_a_x(vax), .vertex_a_y(vay), .vertex_a_z(vaz),
    .vertex_b_x(vbx), .vertex_b_y(vby), .vertex_b_z(vbz),
    .vertex_c_x(vcx), .vertex_c_y(vcy), .vertex_c_z(vcz),
    .led_index(led_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .cos_light_normal(cos_light_normal), .cos_normal_half(cos_normal_half),
    .cos_reflect_view(cos_reflect_view), .degenerate(degenerate)
  );

  always #10 clk = ~clk;

  // Camera copy held by the predictor (Q12.12).
  logic signed [23:0] cam [3];
  shade_t shade_q [$];
  int errors = 0;
  int n_results = 0;
  int n_degen = 0;
  bit stim_done = 1'b0;

  // Light table in Q12.12.
  localparam longint LED_Y [4] = '{1024000, 593920, 143360, -286720};
  localparam longint LED_XZ [4][2] = '{'{351963, 1198675}, '{724653, 1017633},
                                       '{1017633, 724653}, '{1198675, 351963}};

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint round_q14(longint d);
    return (d + 8192) >>> 14;
  endfunction

  function automatic longint clamp_q14(longint v);
    if (v > 16384) return 16384;
    if (v < -16384) return -16384;
    return v;
  endfunction

  // Normalize a vector to Q1.14; returns 0 for a zero-length vector.
  function automatic bit normalize(input longint v [3], output longint u [3]);
    longint unsigned mag [3];
    longint unsigned m, len2, len, q;
    m = 0;
    len2 = 0;
    for (int k = 0; k < 3; k++) begin
      mag[k] = (v[k] < 0) ? -v[k] : v[k];
      if (mag[k] > m) m = mag[k];
      u[k] = 0;
    end
    if (m == 0) return 1'b0;
    while (m >= (64'd1 << 30)) begin
      m >>= 1;
      for (int k = 0; k < 3; k++) mag[k] >>= 1;
    end
    while (m < (64'd1 << 29)) begin
      m <<= 1;
      for (int k = 0; k < 3; k++) mag[k] <<= 1;
    end
    for (int k = 0; k < 3; k++) len2 += mag[k] * mag[k];
    len = int_sqrt(len2);
    for (int k = 0; k < 3; k++) begin
      q = (mag[k] * 16384 + len / 2) / len;
      u[k] = (v[k] < 0) ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  function automatic longint dot_q14(longint a [3], longint b [3]);
    return clamp_q14(round_q14(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]));
  endfunction

  // Predict the shading cosines of one triangle.
  function automatic shade_t shade_triangle(tri_t t);
    longint a [3], b [3], c [3], e1 [3], e2 [3], n [3], s [3];
    longint led3 [3], lv [3], vv [3], hv [3];
    longint nu [3], lu [3], vu [3], hu [3], r [3];
    longint cln, cnh, crv;
    bit okn, okl, okv, okh;
    int row, col;
    shade_t o;
    cln = 0;
    cnh = 0;
    crv = 0;
    for (int k = 0; k < 3; k++) begin
      a[k] = t.v[k];
      b[k] = t.v[3 + k];
      c[k] = t.v[6 + k];
      e1[k] = b[k] - a[k];
      e2[k] = c[k] - a[k];
      s[k] = a[k] + b[k] + c[k];
    end
    n[0] = e1[1] * e2[2] - e1[2] * e2[1];
    n[1] = e1[2] * e2[0] - e1[0] * e2[2];
    n[2] = e1[0] * e2[1] - e1[1] * e2[0];
    row = t.led[3:2];
    col = t.led[1:0];
    led3[0] = 3 * LED_XZ[col][0];
    led3[1] = 3 * LED_Y[row];
    led3[2] = 3 * LED_XZ[col][1];
    for (int k = 0; k < 3; k++) begin
      lv[k] = led3[k] - s[k];
      vv[k] = 3 * longint'(cam[k]) - s[k];
      hv[k] = led3[k] + 3 * longint'(cam[k]) - 2 * s[k];
    end
    okn = normalize(n, nu);
    okl = normalize(lv, lu);
    okv = normalize(vv, vu);
    okh = normalize(hv, hu);
    if (okn && okl) cln = dot_q14(nu, lu);
    if (okn && okh) cnh = dot_q14(nu, hu);
    if (okn && okl && okv) begin
      for (int k = 0; k < 3; k++) r[k] = -lu[k] + round_q14(2 * cln * nu[k]);
      crv = dot_q14(r, vu);
    end
    o.nx = 16'(nu[0]);
    o.ny = 16'(nu[1]);
    o.nz = 16'(nu[2]);
    o.cln = 16'(cln);
    o.cnh = 16'(cnh);
    o.crv = 16'(crv);
    o.degen = !(okn && okl && okv && okh);
    return o;
  endfunction

  // Short idle gap: mostly none or brief, sometimes long.
  function automatic int idle_gap();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // APB write of one camera register.
  task automatic write_camera(logic [1:0] idx, logic signed [23:0] val);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= flc_pkg::ADDR_W'({idx, 2'b00});
    pwdata <= {{8{val[23]}}, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cam[idx] = val;
  endtask

  task automatic set_camera(logic signed [23:0] x, logic signed [23:0] y,
                            logic signed [23:0] z);
    write_camera(flc_pkg::REG_CAMERA_X, x);
    write_camera(flc_pkg::REG_CAMERA_Y, y);
    write_camera(flc_pkg::REG_CAMERA_Z, z);
  endtask

  // Stop offering, wait until every expected result has come, then let the
  // pipe drain.
  task automatic drain();
    in_valid <= 1'b0;
    while (shade_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  // Offer one triangle and hold it until accepted. The input stays valid
  // after acceptance so that the next item can follow without a gap.
  task automatic send_triangle(tri_t t, bit typed, shade_t want);
    shade_t p;
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    p = shade_triangle(t);
    if (typed && p != want)
      $display("%0t: predictor disagrees with typed row", $realtime);
    shade_q.insert(shade_q.size(), typed ? want : p);
    in_valid <= 1'b1;
    {vax, vay, vaz} <= {t.v[0], t.v[1], t.v[2]};
    {vbx, vby, vbz} <= {t.v[3], t.v[4], t.v[5]};
    {vcx, vcy, vcz} <= {t.v[6], t.v[7], t.v[8]};
    led_index <= t.led;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic signed [23:0] rand_coord();
    int p;
    p = $urandom_range(9);
    if (p == 0) return 24'sh7FFFFF;
    if (p == 1) return -24'sh800000;
    if (p < 5) return 24'($urandom);
    return 24'($signed($urandom_range(40000)) - 20000);
  endfunction

  function automatic tri_t rand_triangle();
    tri_t t;
    for (int k = 0; k < 9; k++) t.v[k] = rand_coord();
    // Sometimes repeat the first vertex as the second, making the triangle degenerate.
    if ($urandom_range(19) == 0) for (int k = 0; k < 3; k++) t.v[3 + k] = t.v[k];
    t.led = 4'($urandom);
    return t;
  endfunction

  function automatic tri_t make_tri(longint a0, longint a1, longint a2, longint b0,
                                    longint b1, longint b2, longint c0, longint c1,
                                    longint c2, int led);
    tri_t t;
    t.v[0] = 24'(a0); t.v[1] = 24'(a1); t.v[2] = 24'(a2);
    t.v[3] = 24'(b0); t.v[4] = 24'(b1); t.v[5] = 24'(b2);
    t.v[6] = 24'(c0); t.v[7] = 24'(c1); t.v[8] = 24'(c2);
    t.led = 4'(led);
    return t;
  endfunction

  // Output side: random stalls, compare each result with the oldest prediction.
  initial begin
    shade_t w;
    int g;
    g = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        n_results++;
        if (degenerate) n_degen++;
        if (shade_q.size() == 0) begin
          $display("%0t: unexpected result item", $realtime);
          errors++;
        end else begin
          w = shade_q.pop_front();
          if ({normal_x, normal_y, normal_z} != {w.nx, w.ny, w.nz} ||
              {cos_light_normal, cos_normal_half, cos_reflect_view, degenerate} !=
              {w.cln, w.cnh, w.crv, w.degen}) begin
            $display("%0t: mismatch expected n=(%0d %0d %0d) c=(%0d %0d %0d) d=%0d",
                     $realtime, w.nx, w.ny, w.nz, w.cln, w.cnh, w.crv, w.degen);
            $display("%0t:          actual n=(%0d %0d %0d) c=(%0d %0d %0d) d=%0d",
                     $realtime, normal_x, normal_y, normal_z, cos_light_normal,
                     cos_normal_half, cos_reflect_view, degenerate);
            errors++;
          end
        end
      end
      if (g > 0) begin
        g--;
        out_ready <= 1'b0;
      end else begin
        g = idle_gap();
        out_ready <= (g == 0);
      end
    end
  end

  // Stimulus.
  initial begin
    row_t rows [$];
    row_t r;
    shade_t zero;
    tri_t t;
    zero = '{default: '0};
    zero.degen = 1'b1;
    for (int k = 0; k < 3; k++) cam[k] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed table: degenerate triangles have known all-zero results.
    r.typed = 1'b1; r.want = zero;
    r.t = make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 0); rows.insert(rows.size(), r);
    r.t = make_tri(4096, 4096, 4096, 4096, 4096, 4096, 4096, 4096, 4096, 15);
    rows.insert(rows.size(), r);
    r.t = make_tri(0, 0, 0, 4096, 0, 0, 8192, 0, 0, 5); rows.insert(rows.size(), r);
    r.t = make_tri(8388607, -8388608, 8388607, 8388607, -8388608, 8388607,
                   8388607, -8388608, 8388607, 3);
    rows.insert(rows.size(), r);
    r.typed = 1'b0;
    r.t = make_tri(0, 0, 0, 4096, 0, 0, 0, 4096, 0, 0); rows.insert(rows.size(), r);
    r.t = make_tri(0, 0, 0, 0, 4096, 0, 4096, 0, 0, 15); rows.insert(rows.size(), r);
    r.t = make_tri(8388607, 8388607, 8388607, -8388608, -8388608, 8388607,
                   8388607, -8388608, -8388608, 6);
    rows.insert(rows.size(), r);
    r.t = make_tri(-8388608, -8388608, -8388608, 8388607, 0, 0, 0, 8388607, 0, 9);
    rows.insert(rows.size(), r);
    r.t = make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0, 12); rows.insert(rows.size(), r);
    // Centroid on the light at index 0 makes the light vector zero.
    r.t = make_tri(351963 - 4096, 1024000 - 4096, 1198675, 351963 + 4096,
                   1024000 - 4096, 1198675, 351963, 1024000 + 8192, 1198675, 0);
    rows.insert(rows.size(), r);
    for (int i = 0; i < 16; i++) begin
      r.t = make_tri(-40960, 0, 0, 40960, 0, 4096, 0, 40960, -4096, i);
      rows.insert(rows.size(), r);
    end
    foreach (rows[i]) send_triangle(rows[i].t, rows[i].typed, rows[i].want);
    drain();

    // Random phases over several camera positions, the extremes among them.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_camera(24'sh7FFFFF, -24'sh800000, 24'sh7FFFFF);
        1: set_camera(-24'sh800000, 24'sh7FFFFF, -24'sh800000);
        2: set_camera(24'sd0, 24'sd409600, 24'sd2048000);
        // Camera at the origin: triangles centered there make V zero.
        3: set_camera(24'sd0, 24'sd0, 24'sd0);
        default: set_camera(24'($urandom), 24'($urandom), 24'($urandom));
      endcase
      for (int i = 0; i < 270; i++) begin
        t = rand_triangle();
        if (ph == 3 && $urandom_range(9) == 0)
          t = make_tri(-4096, -4096, 0, 4096, -4096, 0, 0, 8192, 0, $urandom);
        send_triangle(t, 1'b0, zero);
      end
      drain();
    end
    stim_done = 1'b1;
  end

  // End of run.
  initial begin
    wait (stim_done);
    $display("Covered %0d result items (%0d degenerate) over 7 camera settings.",
             n_results, n_degen);
    if (errors == 0 && shade_q.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // Timeout.
  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
